FILE: rtl/mvld_pkg.sv
// ----------------------------------------------------------------------------
// mvld_pkg
// Shared widths, reset values, codes and record types of the motion vector
// line drawer
// ----------------------------------------------------------------------------
package mvld_pkg;

  // field widths
  localparam int COORD_W    = 12;
  localparam int VEC_W      = 11;
  localparam int SAD_W      = 20;
  localparam int SCALE_W    = 5;
  localparam int PEL_W      = 3;
  localparam int TOL_W      = 20;
  localparam int CLIP_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // line geometry
  localparam int MAX_LEN   = 64;
  localparam int FRAC_BITS = 16;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);

  // scaled vector component, signed, and its magnitude
  localparam int PROD_W = SCALE_W + VEC_W + 1;
  localparam int MAG_W  = SCALE_W + VEC_W - 1;

  // shared divider: dividend bits consumed per run and step counter
  localparam int NUM_W  = (FRAC_BITS + 1 > MAG_W) ? FRAC_BITS + 1 : MAG_W;
  localparam int ITER_W = $clog2(NUM_W + 1);

  // slope, minor accumulator, minor offset and pixel position
  localparam int SLOPE_W = FRAC_BITS + 2;
  localparam int ACC_W   = FRAC_BITS + LEN_W + 1;
  localparam int POS_W   = COORD_W + 2;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(1);
  localparam logic [PEL_W-1:0]   PEL_RST       = PEL_W'(1);
  localparam logic [TOL_W-1:0]   TOLERANCE_RST = '1;
  localparam logic [CLIP_W-1:0]  CLIP_RST      = CLIP_W'(4096);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE       = 3'd0,
    CFG_PEL         = 3'd1,
    CFG_TOLERANCE   = 3'd2,
    CFG_CLIP_WIDTH  = 3'd3,
    CFG_CLIP_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [PEL_W-1:0]   pel;
    logic [TOL_W-1:0]   tolerance;
    logic [CLIP_W-1:0]  clip_width;
    logic [CLIP_W-1:0]  clip_height;
  } cfg_t;

  // one classified line, handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic               major_is_y;
    logic               major_negative;
    logic [LEN_W-1:0]   len;
    logic [SLOPE_W-1:0] slope;
  } job_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  den;
    logic [MAG_W-1:0]  rem_init;
    logic [NUM_W-1:0]  num;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIVX,
    F_DIVY,
    F_CLASS,
    F_SLOPE,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

endpackage

FILE: rtl/mvld_if.sv
// ----------------------------------------------------------------------------
// mvld_if
// Valid/ready channels of the line drawer: block requests in, pixel requests
// out
// ----------------------------------------------------------------------------
interface mvld_in_if;
  logic                              valid;
  logic                              ready;
  logic [mvld_pkg::COORD_W-1:0]      start_x;
  logic [mvld_pkg::COORD_W-1:0]      start_y;
  logic signed [mvld_pkg::VEC_W-1:0] vec_x;
  logic signed [mvld_pkg::VEC_W-1:0] vec_y;
  logic [mvld_pkg::SAD_W-1:0]        block_sad;

  modport source (output valid, start_x, start_y, vec_x, vec_y, block_sad, input ready);
  modport sink (input valid, start_x, start_y, vec_x, vec_y, block_sad, output ready);
endinterface

interface mvld_out_if;
  logic                         valid;
  logic                         ready;
  logic [mvld_pkg::COORD_W-1:0] pixel_x;
  logic [mvld_pkg::COORD_W-1:0] pixel_y;
  logic                         write_enable;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, write_enable, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, write_enable, last, output ready);
endinterface

FILE: rtl/mvld_div.sv
// ----------------------------------------------------------------------------
// mvld_div
// Shared restoring divider, one quotient bit per cycle, with a preloadable
// partial remainder and a run length set per request
// ----------------------------------------------------------------------------
module mvld_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mvld_pkg::div_req_t req,
  output mvld_pkg::div_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [mvld_pkg::ITER_W-1:0]     cnt_r;
  logic [mvld_pkg::MAG_W-1:0]      rem_r;
  logic [mvld_pkg::MAG_W-1:0]      rem_nxt;
  logic [mvld_pkg::NUM_W-1:0]      num_r;
  logic [mvld_pkg::NUM_W-1:0]      quo_r;
  logic [mvld_pkg::MAG_W:0]        partial;
  logic [mvld_pkg::MAG_W:0]        diff;
  logic                            take;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    partial = {rem_r, num_r[mvld_pkg::NUM_W-1]};
    diff    = partial - {1'b0, req.den};
    take    = (partial >= {1'b0, req.den});
    rem_nxt = take ? diff[mvld_pkg::MAG_W-1:0] : partial[mvld_pkg::MAG_W-1:0];
  end

  // run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == mvld_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder, dividend and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      num_r <= req.num;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_r << 1;
      quo_r <= {quo_r[mvld_pkg::NUM_W-2:0], take};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

`ifndef ASSERT_OFF
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");
  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r))) else $error("divider done without a run");
`endif

endmodule

FILE: rtl/mvld_front.sv
// ----------------------------------------------------------------------------
// mvld_front
// Accepts a block request, scales and divides the vector, picks the major
// axis, forms the fixed-point slope and queues the line job
// ----------------------------------------------------------------------------
module mvld_front (
  input  logic               clk,
  input  logic               rst_n,
  input  mvld_pkg::cfg_t     cfg,
  mvld_in_if.sink            in_ch,
  output mvld_pkg::div_req_t div_req,
  input  mvld_pkg::div_rsp_t div_rsp,
  output mvld_pkg::job_t     job,
  output logic               push,
  input  logic               full
);

  mvld_pkg::front_state_t state_r;
  mvld_pkg::front_state_t state_nxt;
  logic                   issue_r;
  logic                   issue_nxt;

  logic [mvld_pkg::COORD_W-1:0]       sx_r;
  logic [mvld_pkg::COORD_W-1:0]       sy_r;
  logic signed [mvld_pkg::PROD_W-1:0] prod_x_r;
  logic signed [mvld_pkg::PROD_W-1:0] prod_y_r;
  logic signed [mvld_pkg::PROD_W-1:0] prod_x_c;
  logic signed [mvld_pkg::PROD_W-1:0] prod_y_c;
  logic                               gate_r;
  logic [mvld_pkg::MAG_W-1:0]         lx_r;
  logic [mvld_pkg::MAG_W-1:0]         ly_r;
  logic [mvld_pkg::MAG_W-1:0]         maj_r;
  logic [mvld_pkg::MAG_W-1:0]         min_r;
  logic                               is_y_r;
  logic                               maj_neg_r;
  logic                               min_neg_r;
  logic [mvld_pkg::LEN_W-1:0]         len_r;
  logic [mvld_pkg::SLOPE_W-1:0]       slope_r;

  logic [mvld_pkg::PROD_W-1:0]  abs_x;
  logic [mvld_pkg::PROD_W-1:0]  abs_y;
  logic [mvld_pkg::MAG_W-1:0]   mag_x;
  logic [mvld_pkg::MAG_W-1:0]   mag_y;
  logic [mvld_pkg::PEL_W-1:0]   pel_eff;
  logic                         is_y_c;
  logic [mvld_pkg::MAG_W-1:0]   maj_c;
  logic [mvld_pkg::MAG_W-1:0]   min_c;
  logic [mvld_pkg::LEN_W-1:0]   len_c;
  logic [mvld_pkg::SLOPE_W-1:0] slope_mag;
  logic                         accept;

  // scale the vector components
  always_comb begin
    prod_x_c = $signed({{(mvld_pkg::PROD_W-mvld_pkg::SCALE_W){1'b0}}, cfg.scale}) *
               $signed({{(mvld_pkg::PROD_W-mvld_pkg::VEC_W){in_ch.vec_x[mvld_pkg::VEC_W-1]}},
                        in_ch.vec_x});
    prod_y_c = $signed({{(mvld_pkg::PROD_W-mvld_pkg::SCALE_W){1'b0}}, cfg.scale}) *
               $signed({{(mvld_pkg::PROD_W-mvld_pkg::VEC_W){in_ch.vec_y[mvld_pkg::VEC_W-1]}},
                        in_ch.vec_y});
  end

  // magnitudes, pel divisor, major axis pick and clamped length
  always_comb begin
    abs_x   = prod_x_r[mvld_pkg::PROD_W-1] ? (~prod_x_r + 1'b1) : prod_x_r;
    abs_y   = prod_y_r[mvld_pkg::PROD_W-1] ? (~prod_y_r + 1'b1) : prod_y_r;
    mag_x   = abs_x[mvld_pkg::MAG_W-1:0];
    mag_y   = abs_y[mvld_pkg::MAG_W-1:0];
    pel_eff = (cfg.pel == '0) ? mvld_pkg::PEL_W'(1) : cfg.pel;
    is_y_c  = (ly_r > lx_r);
    maj_c   = is_y_c ? ly_r : lx_r;
    min_c   = is_y_c ? lx_r : ly_r;
    if (!gate_r) begin
      len_c = '0;
    end else if (maj_c > mvld_pkg::MAG_W'(mvld_pkg::MAX_LEN)) begin
      len_c = mvld_pkg::LEN_W'(mvld_pkg::MAX_LEN);
    end else begin
      len_c = mvld_pkg::LEN_W'(maj_c);
    end
    slope_mag = {1'b0, div_rsp.quo[mvld_pkg::FRAC_BITS:0]};
  end

  // sequencer: next state, divider requests, handshakes
  always_comb begin
    state_nxt        = state_r;
    issue_nxt        = 1'b0;
    in_ch.ready      = 1'b0;
    push             = 1'b0;
    div_req.start    = 1'b0;
    div_req.den      = mvld_pkg::MAG_W'(pel_eff);
    div_req.rem_init = '0;
    div_req.num      = mvld_pkg::NUM_W'(mag_x) << (mvld_pkg::NUM_W - mvld_pkg::MAG_W);
    div_req.iters    = mvld_pkg::ITER_W'(mvld_pkg::MAG_W);
    case (state_r)
      mvld_pkg::F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = mvld_pkg::F_DIVX;
          issue_nxt = 1'b1;
        end
      end
      mvld_pkg::F_DIVX: begin
        div_req.start = issue_r;
        if (div_rsp.done) begin
          state_nxt = mvld_pkg::F_DIVY;
          issue_nxt = 1'b1;
        end
      end
      mvld_pkg::F_DIVY: begin
        div_req.start = issue_r;
        div_req.num   = mvld_pkg::NUM_W'(mag_y) << (mvld_pkg::NUM_W - mvld_pkg::MAG_W);
        if (div_rsp.done) begin
          state_nxt = mvld_pkg::F_CLASS;
        end
      end
      mvld_pkg::F_CLASS: begin
        if (len_c == '0) begin
          state_nxt = mvld_pkg::F_PUSH;
        end else begin
          state_nxt = mvld_pkg::F_SLOPE;
          issue_nxt = 1'b1;
        end
      end
      mvld_pkg::F_SLOPE: begin
        // quotient fits FRAC_BITS+1 bits, so the remainder starts preloaded
        div_req.start    = issue_r;
        div_req.den      = maj_r;
        div_req.rem_init = min_r >> 1;
        div_req.num      = mvld_pkg::NUM_W'(min_r[0]) << (mvld_pkg::NUM_W - 1);
        div_req.iters    = mvld_pkg::ITER_W'(mvld_pkg::FRAC_BITS + 1);
        if (div_rsp.done) begin
          state_nxt = mvld_pkg::F_PUSH;
        end
      end
      mvld_pkg::F_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = mvld_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = mvld_pkg::F_IDLE;
      end
    endcase
  end

  assign accept = (state_r == mvld_pkg::F_IDLE) && in_ch.valid;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mvld_pkg::F_IDLE;
      issue_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (accept) begin
      sx_r     <= in_ch.start_x;
      sy_r     <= in_ch.start_y;
      prod_x_r <= prod_x_c;
      prod_y_r <= prod_y_c;
      gate_r   <= (in_ch.block_sad < cfg.tolerance);
    end
    if ((state_r == mvld_pkg::F_DIVX) && div_rsp.done) begin
      lx_r <= div_rsp.quo[mvld_pkg::MAG_W-1:0];
    end
    if ((state_r == mvld_pkg::F_DIVY) && div_rsp.done) begin
      ly_r <= div_rsp.quo[mvld_pkg::MAG_W-1:0];
    end
    if (state_r == mvld_pkg::F_CLASS) begin
      is_y_r    <= is_y_c;
      maj_r     <= maj_c;
      min_r     <= min_c;
      maj_neg_r <= is_y_c ? prod_y_r[mvld_pkg::PROD_W-1] : prod_x_r[mvld_pkg::PROD_W-1];
      min_neg_r <= is_y_c ? prod_x_r[mvld_pkg::PROD_W-1] : prod_y_r[mvld_pkg::PROD_W-1];
      len_r     <= len_c;
      slope_r   <= '0;
    end
    if ((state_r == mvld_pkg::F_SLOPE) && div_rsp.done) begin
      slope_r <= min_neg_r ? (~slope_mag + 1'b1) : slope_mag;
    end
  end

  // job record
  always_comb begin
    job.origin_x       = sx_r;
    job.origin_y       = sy_r;
    job.major_is_y     = is_y_r;
    job.major_negative = maj_neg_r;
    job.len            = len_r;
    job.slope          = slope_r;
  end

endmodule

FILE: rtl/mvld_queue.sv
// ----------------------------------------------------------------------------
// mvld_queue
// Short job queue between the front and the back
// ----------------------------------------------------------------------------
module mvld_queue #(
  parameter int DEPTH = mvld_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mvld_pkg::job_t push_job,
  input  logic           pop,
  output mvld_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mvld_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push |-> !full) and (pop |-> !empty)) else $error("job queue over or underrun");
`endif

endmodule

FILE: rtl/mvld_back.sv
// ----------------------------------------------------------------------------
// mvld_back
// Walks one queued line along its major axis, one pixel request per cycle
// while out_ch.ready is high, with clipping and a registered output stage
// ----------------------------------------------------------------------------
module mvld_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mvld_pkg::cfg_t cfg,
  input  mvld_pkg::job_t job,
  input  logic           empty,
  output logic           pop,
  mvld_out_if.source     out_ch
);

  mvld_pkg::back_state_t state_r;
  mvld_pkg::back_state_t state_nxt;

  mvld_pkg::job_t               job_r;
  logic [mvld_pkg::LEN_W-1:0]   k_r;
  logic [mvld_pkg::ACC_W-1:0]   acc_r;
  logic                         ovalid_r;
  logic [mvld_pkg::COORD_W-1:0] ox_r;
  logic [mvld_pkg::COORD_W-1:0] oy_r;
  logic                         owe_r;
  logic                         olast_r;

  logic                         emit;
  logic                         last_c;
  logic                         inside_c;
  logic                         we_c;
  logic [mvld_pkg::POS_W-1:0]   off_ext;
  logic [mvld_pkg::POS_W-1:0]   major_step;
  logic [mvld_pkg::POS_W-1:0]   px;
  logic [mvld_pkg::POS_W-1:0]   py;

  // pixel position: major step and floored minor offset
  always_comb begin
    off_ext    = mvld_pkg::POS_W'($signed(acc_r[mvld_pkg::ACC_W-1:mvld_pkg::FRAC_BITS]));
    major_step = job_r.major_negative ? (~mvld_pkg::POS_W'(k_r) + 1'b1)
                                      : mvld_pkg::POS_W'(k_r);
    px = mvld_pkg::POS_W'(job_r.origin_x) + (job_r.major_is_y ? off_ext : major_step);
    py = mvld_pkg::POS_W'(job_r.origin_y) + (job_r.major_is_y ? major_step : off_ext);
    inside_c = !px[mvld_pkg::POS_W-1] && !py[mvld_pkg::POS_W-1] &&
               (px[mvld_pkg::POS_W-2:mvld_pkg::COORD_W] == '0) &&
               (py[mvld_pkg::POS_W-2:mvld_pkg::COORD_W] == '0) &&
               (mvld_pkg::CLIP_W'(px[mvld_pkg::COORD_W-1:0]) < cfg.clip_width) &&
               (mvld_pkg::CLIP_W'(py[mvld_pkg::COORD_W-1:0]) < cfg.clip_height);
    we_c   = (job_r.len != '0) && inside_c;
    last_c = (job_r.len == '0) || (k_r == job_r.len - 1'b1);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    case (state_r)
      mvld_pkg::B_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = mvld_pkg::B_RUN;
        end
      end
      mvld_pkg::B_RUN: begin
        emit = !ovalid_r || out_ch.ready;
        if (emit && last_c) begin
          state_nxt = mvld_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = mvld_pkg::B_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mvld_pkg::B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // line walk and output stage
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
      k_r   <= '0;
      acc_r <= '0;
    end else if (emit) begin
      k_r   <= k_r + 1'b1;
      acc_r <= acc_r + mvld_pkg::ACC_W'($signed(job_r.slope));
    end
    if (emit) begin
      ox_r    <= we_c ? px[mvld_pkg::COORD_W-1:0] : '0;
      oy_r    <= we_c ? py[mvld_pkg::COORD_W-1:0] : '0;
      owe_r   <= we_c;
      olast_r <= last_c;
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.pixel_x      = ox_r;
  assign out_ch.pixel_y      = oy_r;
  assign out_ch.write_enable = owe_r;
  assign out_ch.last         = olast_r;

`ifndef ASSERT_OFF
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == mvld_pkg::B_RUN) && (job_r.len != '0)) |-> (k_r < job_r.len))
    else $error("step count ran past line length");
  a_clipped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !owe_r) |-> ((ox_r == '0) && (oy_r == '0)))
    else $error("suppressed pixel carries coordinates");
`endif

endmodule

FILE: rtl/motion_vector_line_drawer.sv
// ----------------------------------------------------------------------------
// motion_vector_line_drawer
// Draws one motion vector per block request as a run of pixel write requests
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : valid/ready block request (start_x, start_y, vec_x, vec_y,
//            block_sad); accepted when valid and ready are both high
//   out_ch : valid/ready pixel request (pixel_x, pixel_y, write_enable,
//            last); one request per step of the line, last marks the end
//   cfg_*  : write port, cfg_index selects scale, pel, tolerance,
//            clip_width or clip_height; write only while the block is idle
// Timing
//   The front runs two 15-step pel divisions and one 17-step slope division
//   in the shared divider on a drawn vector, and only the two pel divisions
//   on a gated or empty one. The back then gives one pixel request per cycle
//   while out_ch.ready is high, up to 64 pixels per line. A two-entry job
//   queue lets the front work on the next request while the back draws, so
//   the sustained rate is set by the slower of the two.
// Reset
//   Synchronous, active low: registers return to scale 1, pel 1, full
//   tolerance and a 4096 by 4096 clip window; queue and output are emptied.
// Stall
//   While out_ch.ready is low the pending request holds and the line walk
//   waits; the front keeps filling the queue and then holds in_ch.ready low.
// ----------------------------------------------------------------------------
module motion_vector_line_drawer #(
  parameter int QUEUE_DEPTH = mvld_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mvld_in_if.sink                           in_ch,
  mvld_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mvld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvld_pkg::CFG_DATA_W-1:0]   cfg_data
);

  mvld_pkg::cfg_t     cfg_r;
  mvld_pkg::cfg_t     cfg_nxt;
  mvld_pkg::div_req_t div_req;
  mvld_pkg::div_rsp_t div_rsp;
  mvld_pkg::job_t     push_job;
  mvld_pkg::job_t     pop_job;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mvld_pkg::CFG_SCALE:       cfg_nxt.scale       = cfg_data[mvld_pkg::SCALE_W-1:0];
        mvld_pkg::CFG_PEL:         cfg_nxt.pel         = cfg_data[mvld_pkg::PEL_W-1:0];
        mvld_pkg::CFG_TOLERANCE:   cfg_nxt.tolerance   = cfg_data[mvld_pkg::TOL_W-1:0];
        mvld_pkg::CFG_CLIP_WIDTH:  cfg_nxt.clip_width  = cfg_data[mvld_pkg::CLIP_W-1:0];
        mvld_pkg::CFG_CLIP_HEIGHT: cfg_nxt.clip_height = cfg_data[mvld_pkg::CLIP_W-1:0];
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale       <= mvld_pkg::SCALE_RST;
      cfg_r.pel         <= mvld_pkg::PEL_RST;
      cfg_r.tolerance   <= mvld_pkg::TOLERANCE_RST;
      cfg_r.clip_width  <= mvld_pkg::CLIP_RST;
      cfg_r.clip_height <= mvld_pkg::CLIP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // shared divider
  mvld_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // front: accept and classify
  mvld_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .job     (push_job),
    .push    (push),
    .full    (full)
  );

  // job queue
  mvld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  // back: line walk
  mvld_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .job    (pop_job),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
